[rtl/core/chd_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the Huffman decoder.
package chd_pkg;

  localparam int WIN_W       = 32;  // bit window width
  localparam int CNT_W       = 6;   // bit count, 0..32
  localparam int LEN_W       = 5;   // code length / max_code_len register
  localparam int MSG_W       = 32;  // message length and symbol counter
  localparam int CFG_W       = 32;  // config write data
  localparam int CFG_IDX_W   = 1;
  localparam int INDEX_W     = 10;
  localparam int LIMIT_W     = 25;
  localparam int BASE_W      = 24;
  localparam int OFFSET_W    = 10;
  localparam int SYMBOL_W    = 16;
  localparam int CHUNK_W     = 8;
  localparam int CHUNK_CNT_W = 4;
  localparam int RESULT_CAP  = 8;   // max words out per input word

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 5'd16;

  typedef enum logic [1:0] {
    MODE_ROW     = 2'd0,
    MODE_SLOT    = 2'd1,
    MODE_CHUNK   = 2'd2,
    MODE_RESTART = 2'd3
  } chd_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN = 1'b0,
    CFG_MSG_LEN = 1'b1
  } chd_cfg_idx_t;

  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic extract;  // latch top window bits
    logic match;    // latch length from limit compares
    logic consume;  // form slot, drop code bits, count symbol
    logic read;     // symbol table read
    logic emit;     // load output register
  } chd_cmd_t;

  typedef struct packed {
    logic can_decode;  // enough bits and message not finished
    logic out_free;    // output register can take a word
    logic last;        // word being emitted ends this input word
  } chd_stat_t;

endpackage

[rtl/core/chd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module chd_ram
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
)
(
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/chd_ctrl.sv]
// Sequencing state machine for the Huffman decoder.
module chd_ctrl
  import chd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  chd_stat_t  stat,
  output chd_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EXTRACT = 6'b000010,
    ST_MATCH   = 6'b000100,
    ST_SLOT    = 6'b001000,
    ST_READ    = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_mode == MODE_CHUNK) begin
            state_nxt = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        if (stat.can_decode) begin
          cmd.extract = 1'b1;
          state_nxt   = ST_MATCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        cmd.consume = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? ST_IDLE : ST_EXTRACT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/chd_dp.sv]
// Datapath: config registers, bit window, length rows, symbol table and output register.
module chd_dp
  import chd_pkg::*;
#(
  parameter int MAX_CODE_LEN = 24,
  parameter int TABLE_DEPTH  = 1024,
  parameter int CHUNK_BITS   = 8,
  parameter int SYMBOL_BITS  = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [1:0]             in_mode,
  input  logic [INDEX_W-1:0]     in_index,
  input  logic [LIMIT_W-1:0]     in_limit_value,
  input  logic [BASE_W-1:0]      in_base_value,
  input  logic [OFFSET_W-1:0]    in_offset_value,
  input  logic [SYMBOL_W-1:0]    in_symbol_value,
  input  logic [CHUNK_W-1:0]     in_bit_chunk,
  input  logic [CHUNK_CNT_W-1:0] in_chunk_bits,
  input  chd_cmd_t               cmd,
  output chd_stat_t              stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYMBOL_W-1:0]    out_symbol,
  output logic [LEN_W-1:0]       out_code_length,
  output logic                   out_last,
  output logic                   out_code_error,
  output logic                   out_message_done
);

  localparam int RW    = $clog2(MAX_CODE_LEN + 1);
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int SYM_W = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
  localparam int NW    = $clog2(RESULT_CAP);

  function automatic logic [WIN_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WIN_W:0] m;
    m = ({{WIN_W{1'b0}}, 1'b1} << n) - {{WIN_W{1'b0}}, 1'b1};
    return m[WIN_W-1:0];
  endfunction

  // config
  logic [LEN_W-1:0] max_len_r;
  logic [MSG_W-1:0] msg_len_r;
  logic [LEN_W-1:0] win_len;

  // window state
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MSG_W-1:0] dec_r, dec_nxt;

  // per-length rows, entry 0 unused
  logic [LIMIT_W-1:0]  limit_r  [MAX_CODE_LEN+1];
  logic [BASE_W-1:0]   base_r   [MAX_CODE_LEN+1];
  logic [OFFSET_W-1:0] offset_r [MAX_CODE_LEN+1];

  // symbol step registers
  logic [WIN_W-1:0] v_r;
  logic             found_r;
  logic [RW-1:0]    len_r;
  logic [WIN_W-1:0] slot_r;
  logic             err_r;
  logic [LEN_W-1:0] used_r;
  logic [NW-1:0]    n_r;

  logic             out_valid_r;
  logic [SYMBOL_W-1:0] out_symbol_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r, out_err_r, out_done_r;

  logic [CHUNK_CNT_W-1:0] nb;
  logic [WIN_W-1:0]       chunk;
  logic [CNT_W:0]         app_sum;
  logic [CNT_W-1:0]       ext_shift;
  logic [WIN_W-1:0]       v_w;
  logic                   match_found;
  logic [RW-1:0]          match_len;
  logic [LEN_W-1:0]       used_w;
  logic [WIN_W-1:0]       code_w, slot_w;
  logic                   err_w;
  logic                   row_we, sym_we;
  logic [WIN_W-1:0]       idx_ext;
  logic [SYM_W-1:0]       ram_rdata;

  always_comb begin
    if (max_len_r == '0) begin
      win_len = LEN_W'(1);
    end else if (max_len_r > LEN_W'(MAX_CODE_LEN)) begin
      win_len = LEN_W'(MAX_CODE_LEN);
    end else begin
      win_len = max_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      msg_len_r <= '0;
    end else if (cfg_we) begin
      case (chd_cfg_idx_t'(cfg_index))
        CFG_MAX_LEN: max_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_MSG_LEN: msg_len_r <= cfg_wdata[MSG_W-1:0];
        default: ;
      endcase
    end
  end

  // chunk append
  assign nb      = ({2'b00, in_chunk_bits} > 6'(CHUNK_BITS)) ? CHUNK_CNT_W'(CHUNK_BITS)
                                                             : in_chunk_bits;
  assign chunk   = WIN_W'(in_bit_chunk) & low_mask(CNT_W'(nb));
  assign app_sum = {1'b0, cnt_r} + (CNT_W+1)'(nb);

  // top window bits
  assign ext_shift = cnt_r - {1'b0, win_len};
  assign v_w       = (win_r >> ext_shift) & low_mask({1'b0, win_len});

  // shortest length whose limit lies above the window value
  always_comb begin
    match_found = 1'b0;
    match_len   = '0;
    for (int i = 1; i <= MAX_CODE_LEN; i++) begin
      if (!match_found && (LEN_W'(i) <= win_len) &&
          ({{(WIN_W-LIMIT_W){1'b0}}, limit_r[i]} > v_r)) begin
        match_found = 1'b1;
        match_len   = RW'(i);
      end
    end
  end

  // slot = code - base + offset, wraps at 32 bits
  assign used_w = found_r ? LEN_W'(len_r) : win_len;
  assign code_w = v_r >> (win_len - LEN_W'(len_r));
  assign slot_w = code_w - WIN_W'(base_r[len_r]) + WIN_W'(offset_r[len_r]);
  assign err_w  = !found_r || (slot_w >= WIN_W'(TABLE_DEPTH));

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    dec_nxt = dec_r;
    if (cmd.accept) begin
      case (chd_mode_t'(in_mode))
        MODE_RESTART: begin
          win_nxt = '0;
          cnt_nxt = '0;
          dec_nxt = '0;
        end
        MODE_CHUNK: begin
          if ((dec_r < msg_len_r) && (app_sum <= (CNT_W+1)'(WIN_W))) begin
            win_nxt = (win_r << nb) | chunk;
            cnt_nxt = app_sum[CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end else if (cmd.consume) begin
      cnt_nxt = cnt_r - {1'b0, used_w};
      win_nxt = win_r & low_mask(cnt_nxt);
      dec_nxt = dec_r + MSG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
      dec_r <= '0;
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
      dec_r <= dec_nxt;
    end
  end

  assign row_we  = cmd.accept && (in_mode == MODE_ROW) && (in_index != '0) &&
                   (in_index <= INDEX_W'(MAX_CODE_LEN));
  assign idx_ext = WIN_W'(in_index);
  assign sym_we  = cmd.accept && (in_mode == MODE_SLOT) && (idx_ext < WIN_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (row_we) begin
      limit_r[in_index[RW-1:0]]  <= in_limit_value;
      base_r[in_index[RW-1:0]]   <= in_base_value;
      offset_r[in_index[RW-1:0]] <= in_offset_value;
    end
  end

  chd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_symbol_value[SYM_W-1:0]),
    .re    (cmd.read),
    .raddr (slot_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // step registers, payload only
  always_ff @(posedge clk) begin
    if (cmd.extract) begin
      v_r <= v_w;
    end
    if (cmd.match) begin
      found_r <= match_found;
      len_r   <= match_len;
    end
    if (cmd.consume) begin
      slot_r <= slot_w;
      err_r  <= err_w;
      used_r <= used_w;
    end
  end

  assign stat.can_decode = (dec_r < msg_len_r) && (cnt_r >= {1'b0, win_len});
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last       = !((n_r != NW'(RESULT_CAP - 1)) && stat.can_decode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        n_r <= '0;
      end else if (cmd.emit) begin
        n_r <= n_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_symbol_r <= err_r ? '0 : SYMBOL_W'(ram_rdata);
      out_len_r    <= used_r;
      out_last_r   <= stat.last;
      out_err_r    <= err_r;
      out_done_r   <= (dec_r == msg_len_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_code_length  = out_len_r;
  assign out_last         = out_last_r;
  assign out_code_error   = out_err_r;
  assign out_message_done = out_done_r;

`ifndef ASSERT_OFF
  a_win_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r & ~low_mask(cnt_r)) == '0)
    else $error("window holds bits above bit count");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.consume |-> (cnt_r >= {1'b0, used_w}))
    else $error("consumed more bits than held");

  a_dec_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.consume |=> (dec_r == $past(dec_r) + MSG_W'(1)))
    else $error("symbol count did not advance");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("output word overwritten");
`endif

endmodule

[rtl/core/canonical_huffman_decoder.sv]
// Canonical Huffman decoder top level: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one word per item. in_mode selects:
//   row load (limit/base/offset for length in_index), symbol slot load,
//   bit chunk (in_chunk_bits bits of in_bit_chunk, MSB first), or restart.
// Output channel (out_valid/out_ready) carries decoded symbols; out_last marks
//   the final symbol caused by one chunk word, at most eight per chunk.
// cfg_we/cfg_index/cfg_wdata write max_code_len (index 0) and message_length
//   (index 1); write only while the block is idle.
// Sequence: row, slot and restart words are taken in the idle state. A chunk word
//   is appended, then each decoded symbol steps through extract, limit compare,
//   slot add, symbol RAM read and output load; a chunk yielding nothing
//   returns to idle at the extract check. The five-step symbol sequence sets the rate.
// A single output register decouples the sides: the next symbol is worked out
//   while the previous word waits; when out_ready stays low the sequencer holds
//   in its output step and in_ready stays low until the chunk is finished.
// Reset (rst_n, synchronous) empties the window, clears the symbol counter,
//   sets max_code_len to 16 and message_length to 0. Length rows and the symbol
//   table are not cleared and must be loaded before use.
module canonical_huffman_decoder
  import chd_pkg::*;
#(
  parameter int MAX_CODE_LEN = 24,
  parameter int TABLE_DEPTH  = 1024,
  parameter int CHUNK_BITS   = 8,
  parameter int SYMBOL_BITS  = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [INDEX_W-1:0]     in_index,
  input  logic [LIMIT_W-1:0]     in_limit_value,
  input  logic [BASE_W-1:0]      in_base_value,
  input  logic [OFFSET_W-1:0]    in_offset_value,
  input  logic [SYMBOL_W-1:0]    in_symbol_value,
  input  logic [CHUNK_W-1:0]     in_bit_chunk,
  input  logic [CHUNK_CNT_W-1:0] in_chunk_bits,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYMBOL_W-1:0]    out_symbol,
  output logic [LEN_W-1:0]       out_code_length,
  output logic                   out_last,
  output logic                   out_code_error,
  output logic                   out_message_done
);

  chd_cmd_t  cmd;   // controller -> datapath step strobes
  chd_stat_t stat;  // datapath -> controller decode status

  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chd_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .TABLE_DEPTH  (TABLE_DEPTH),
    .CHUNK_BITS   (CHUNK_BITS),
    .SYMBOL_BITS  (SYMBOL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_index         (in_index),
    .in_limit_value   (in_limit_value),
    .in_base_value    (in_base_value),
    .in_offset_value  (in_offset_value),
    .in_symbol_value  (in_symbol_value),
    .in_bit_chunk     (in_bit_chunk),
    .in_chunk_bits    (in_chunk_bits),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_code_length  (out_code_length),
    .out_last         (out_last),
    .out_code_error   (out_code_error),
    .out_message_done (out_message_done)
  );

endmodule
